/* design/tpc_stream_trigger_primitive_decoder_macros.svh */
// assertion macros shared by the tpc stream decoder modules
`ifndef TPC_STREAM_TRIGGER_PRIMITIVE_DECODER_MACROS_SVH
`define TPC_STREAM_TRIGGER_PRIMITIVE_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TPCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/tpcd_pkg.sv */
// shared types and constants of the tpc stream trigger primitive decoder
package tpcd_pkg;

	localparam int MAX_RESULTS = 3;

	typedef enum logic [1:0] {
		KIND_FRAME   = 2'd0,
		KIND_FEM     = 2'd1,
		KIND_CHANNEL = 2'd2,
		KIND_PRIM    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t        kind;
		logic [23:0]  frame_number;
		logic         frame_missing;
		logic [4:0]   fem_number;
		logic [5:0]   channel_number;
		logic [11:0]  peak;
		logic [15:0]  duration;
		logic [27:0]  integral;
		logic [13:0]  start_time;
		logic         last;
	} result_t;

	typedef struct packed {
		logic         header_active;
		logic [3:0]   header_count;
		logic [11:0]  frame_high;
		logic [5:0]   frame_middle;
		logic [23:0]  expected_frame;
		logic [5:0]   current_channel;
		logic [13:0]  region_time;
		logic [11:0]  region_peak;
		logic [15:0]  region_count;
		logic [27:0]  region_sum;
	} state_t;

	// results of one word, compacted to the low slots
	typedef struct packed {
		result_t [MAX_RESULTS-1:0] r;
		logic [1:0]                cnt;
	} batch_t;

	localparam state_t STATE_RESET = '{expected_frame: '1, default: '0};

endpackage

/* design/tpc_stream_trigger_primitive_decoder.sv */
// top level of the tpc stream trigger primitive decoder
// path: a taken word is registered in the input stage, decoded, and its results registered in the queue
// throughput: one word per cycle while each word yields at most one result and results
// are taken every cycle; after a word with two or three results the next word with results
// waits in the input stage until the last of them is being taken
// reset: arst_n clears control and decoder state at once, expected frame goes to all ones
`include "tpc_stream_trigger_primitive_decoder_macros.svh"

module tpc_stream_trigger_primitive_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	output logic        word_ready,
	input  logic [31:0] word,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  kind,
	output logic [23:0] frame_number,
	output logic        frame_missing,
	output logic [4:0]  fem_number,
	output logic [5:0]  channel_number,
	output logic [11:0] peak,
	output logic [15:0] duration,
	output logic [27:0] integral,
	output logic [13:0] start_time,
	output logic        last
);

	// input stage: one registered word waiting for decode
	logic              valid_s1;
	logic [31:0]       word_s1;

	// decoder state: header tracking, frame bits, current channel and region
	tpcd_pkg::state_t  state_q;
	tpcd_pkg::state_t  state_nxt;
	tpcd_pkg::batch_t  batch;

	// queue side
	logic              can_load;
	logic              advance;
	logic              load;
	tpcd_pkg::result_t head;

	// a word with no results never waits; otherwise the queue must be free
	// by the coming edge, which lets a single-result word follow every cycle while results are taken
	assign advance    = valid_s1 && (batch.cnt == 2'd0 || can_load);
	assign load       = advance && batch.cnt != 2'd0;
	assign word_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (word_ready) begin
			valid_s1 <= word_valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (word_valid && word_ready) begin
			word_s1 <= word;
		end
	end

	// state moves exactly once per decoded item, in item order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpcd_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// all per-word decode: header count, frame rebuild, fem marker, both halves
	tpcd_decode u_decode (
		.word  (word_s1),
		.cur   (state_q),
		.nxt   (state_nxt),
		.batch (batch)
	);

	// output register plus room for the extra results of one word
	tpcd_res_q u_res_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.batch     (batch),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.head      (head),
		.can_load  (can_load)
	);

	assign kind           = head.kind;
	assign frame_number   = head.frame_number;
	assign frame_missing  = head.frame_missing;
	assign fem_number     = head.fem_number;
	assign channel_number = head.channel_number;
	assign peak           = head.peak;
	assign duration       = head.duration;
	assign integral       = head.integral;
	assign start_time     = head.start_time;
	assign last           = head.last;

	`TPCD_ASSERT_NEXT(a_s1_fill, clk, arst_n, word_valid && word_ready, valid_s1, "accepted item missing from input stage")
	`TPCD_ASSERT_NOW(a_hdr_idle, clk, arst_n, !state_q.header_active, state_q.header_count == 4'd0, "header count running while header inactive")
	`TPCD_ASSERT_NOW(a_region_empty, clk, arst_n, state_q.region_count == 16'd0, state_q.region_peak == 12'd0 && state_q.region_sum == 28'd0, "empty region holds peak or sum")

endmodule

/* design/tpcd_decode.sv */
// combinational decode of one readout word against the decoder state
module tpcd_decode (
	input  logic [31:0]      word,
	input  tpcd_pkg::state_t cur,
	output tpcd_pkg::state_t nxt,
	output tpcd_pkg::batch_t batch
);

	localparam logic [31:0] START_WORD     = 32'hFFFF_FFFF;
	localparam logic [31:0] IGNORE_WORD    = 32'hE000_0000;
	localparam logic [7:0]  FEM_MARKER     = 8'hF1;
	localparam logic [15:0] FEM_LOW        = 16'hFFFF;
	localparam logic [3:0]  HALF_CHANNEL   = 4'h1;
	localparam logic [1:0]  HALF_TIME      = 2'b01;
	localparam logic [3:0]  HALF_SAMPLE_A  = 4'h2;
	localparam logic [3:0]  HALF_SAMPLE_B  = 4'h3;
	localparam logic [3:0]  HDR_COUNT_MAX  = 4'd15;
	localparam logic [3:0]  HDR_FRAME_HIGH = 4'd5;
	localparam logic [3:0]  HDR_FRAME_LOW  = 4'd8;
	localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
	localparam logic [27:0] SUM_MAX        = 28'hFFF_FFFF;

	typedef struct packed {
		tpcd_pkg::state_t  s;
		logic              emit;
		tpcd_pkg::result_t r;
	} half_t;

	function automatic half_t decode_half(tpcd_pkg::state_t s, logic [15:0] h);
		half_t       o;
		logic [11:0] smp;
		logic [28:0] sum_w;
		o      = '0;
		o.s    = s;
		smp    = h[11:0];
		sum_w  = {1'b0, s.region_sum} + {17'd0, smp};
		if (h[15:12] == HALF_CHANNEL) begin
			o.s.current_channel  = h[5:0];
			o.s.region_peak      = '0;
			o.s.region_count     = '0;
			o.s.region_sum       = '0;
			o.emit               = 1'b1;
			o.r.kind             = tpcd_pkg::KIND_CHANNEL;
			o.r.channel_number   = h[5:0];
		end else if (h[15:14] == HALF_TIME) begin
			if (s.region_count != '0 && s.region_peak != '0 && s.region_sum != '0) begin
				o.emit             = 1'b1;
				o.r.kind           = tpcd_pkg::KIND_PRIM;
				o.r.channel_number = s.current_channel;
				o.r.peak           = s.region_peak;
				o.r.duration       = s.region_count;
				o.r.integral       = s.region_sum;
				o.r.start_time     = s.region_time;
			end
			o.s.region_time  = h[13:0];
			o.s.region_peak  = '0;
			o.s.region_count = '0;
			o.s.region_sum   = '0;
		end else if (h[15:12] == HALF_SAMPLE_A || h[15:12] == HALF_SAMPLE_B) begin
			if (s.region_count != COUNT_MAX)
				o.s.region_count = s.region_count + 16'd1;
			if (smp > s.region_peak)
				o.s.region_peak = smp;
			o.s.region_sum = sum_w[28] ? SUM_MAX : sum_w[27:0];
		end
		return o;
	endfunction

	logic [15:0]       lo;
	logic [15:0]       hi;
	tpcd_pkg::state_t  s;
	half_t             lo_o;
	half_t             hi_o;
	logic [5:0]        low6;
	logic              got;
	logic [23:0]       fr;
	tpcd_pkg::result_t cand   [4];
	logic              cand_v [4];
	logic [1:0]        n;

	assign lo = word[15:0];
	assign hi = word[31:16];

	always_comb begin
		s      = cur;
		got    = 1'b0;
		low6   = '0;
		fr     = '0;
		lo_o   = '0;
		hi_o   = '0;
		for (int i = 0; i < 4; i++) begin
			cand[i]   = '0;
			cand_v[i] = 1'b0;
		end
		if (word == START_WORD) begin
			s.header_active = 1'b1;
			s.header_count  = 4'd1;
		end else if (word != IGNORE_WORD) begin
			if (s.header_active) begin
				if (s.header_count != HDR_COUNT_MAX)
					s.header_count = s.header_count + 4'd1;
				if (s.header_count == HDR_FRAME_HIGH) begin
					s.frame_high   = lo[11:0];
					s.frame_middle = hi[11:6];
				end
				if (s.header_count == HDR_FRAME_LOW) begin
					// low half wins when both halves are channel headers
					if (lo[15:12] == HALF_CHANNEL) begin
						got  = 1'b1;
						low6 = lo[11:6];
					end else if (hi[15:12] == HALF_CHANNEL) begin
						got  = 1'b1;
						low6 = hi[11:6];
					end
					if (got) begin
						fr                    = {s.frame_high, s.frame_middle, low6};
						cand_v[0]             = 1'b1;
						cand[0].kind          = tpcd_pkg::KIND_FRAME;
						cand[0].frame_number  = fr;
						cand[0].frame_missing = (s.expected_frame + 24'd1) != fr;
						s.expected_frame      = fr;
						s.header_active       = 1'b0;
						s.header_count        = '0;
					end
				end
			end
			if (hi[15:8] == FEM_MARKER && lo == FEM_LOW) begin
				cand_v[1]          = 1'b1;
				cand[1].kind       = tpcd_pkg::KIND_FEM;
				cand[1].fem_number = hi[4:0];
			end
			lo_o      = decode_half(s, lo);
			hi_o      = decode_half(lo_o.s, hi);
			s         = hi_o.s;
			cand_v[2] = lo_o.emit;
			cand[2]   = lo_o.r;
			cand_v[3] = hi_o.emit;
			cand[3]   = hi_o.r;
		end
	end

	// pack the emitted results in order and flag the final one
	always_comb begin
		batch = '0;
		n     = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i] && n != 2'd3) begin
				batch.r[n] = cand[i];
				n          = n + 2'd1;
			end
		end
		for (int j = 0; j < tpcd_pkg::MAX_RESULTS; j++)
			batch.r[j].last = (n != 2'd0) && (2'(j) == n - 2'd1);
		batch.cnt = n;
	end

	assign nxt = s;

endmodule

/* design/tpcd_res_q.sv */
// result queue that takes a word's results at once and hands them out one per cycle while res_ready is high
`include "tpc_stream_trigger_primitive_decoder_macros.svh"

module tpcd_res_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tpcd_pkg::batch_t  batch,
	input  logic              res_ready,
	output logic              res_valid,
	output tpcd_pkg::result_t head,
	output logic              can_load
);

	tpcd_pkg::result_t pend_q [tpcd_pkg::MAX_RESULTS];
	logic [1:0]        cnt_q;
	logic              pop;

	assign res_valid = cnt_q != 2'd0;
	assign pop       = res_valid && res_ready;
	assign can_load  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign head      = pend_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= batch.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < tpcd_pkg::MAX_RESULTS; i++)
				pend_q[i] <= batch.r[i];
		end else if (pop) begin
			for (int i = 0; i < tpcd_pkg::MAX_RESULTS - 1; i++)
				pend_q[i] <= pend_q[i+1];
		end
	end

	`TPCD_ASSERT_NOW(a_load_nonempty, clk, arst_n, load, batch.cnt != 2'd0 && can_load, "queue loaded with empty batch or while busy")
	`TPCD_ASSERT_NOW(a_tail_last, clk, arst_n, res_valid && cnt_q == 2'd1, head.last, "final queued result lacks last flag")
	`TPCD_ASSERT_NEXT(a_drain, clk, arst_n, pop && cnt_q == 2'd1 && !load, !res_valid, "queue did not drain after final pop")

endmodule

/* verif/tpcd_tb_pkg.sv */
// word and half-word codes shared by the decoder testbench and its checker
`timescale 1ns / 100ps

package tpcd_tb_pkg;

	localparam logic [31:0] START_WORD = 32'hFFFF_FFFF;
	localparam logic [31:0] SKIP_WORD  = 32'hE000_0000;

	// fem marker: high byte of the upper half, lower half all ones
	localparam logic [7:0]  FEM_MARK = 8'hF1;
	localparam logic [15:0] FEM_LOW  = 16'hFFFF;

	// half-word tags
	localparam logic [3:0] CHAN_TAG     = 4'h1;
	localparam logic [1:0] TIME_TAG     = 2'b01;
	localparam logic [3:0] SAMPLE_TAG_A = 4'h2;
	localparam logic [3:0] SAMPLE_TAG_B = 4'h3;
	localparam logic [3:0] IDLE_TAG     = 4'h0;

endpackage

/* verif/tpcd_result_checker.sv */
// checker: mirrors the decoder per accepted word and compares every result item
`timescale 1ns / 100ps

module tpcd_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	input  logic        word_ready,
	input  logic [31:0] word,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [1:0]  kind,
	input  logic [23:0] frame_number,
	input  logic        frame_missing,
	input  logic [4:0]  fem_number,
	input  logic [5:0]  channel_number,
	input  logic [11:0] peak,
	input  logic [15:0] duration,
	input  logic [27:0] integral,
	input  logic [13:0] start_time,
	input  logic        last,
	output int          outstanding,
	output int          fail_count
);

	localparam logic [3:0]  FRAME_HIGH_WORD  = 4'd5;
	localparam logic [3:0]  FRAME_LOW_WORD   = 4'd8;
	localparam logic [3:0]  COUNT_CEILING    = 4'd15;
	localparam logic [15:0] DURATION_CEILING = 16'hFFFF;
	localparam logic [27:0] SUM_CEILING      = 28'hFFF_FFFF;

	tpcd_pkg::state_t  mirror;
	tpcd_pkg::result_t pending_results[$];
	int                word_hits;
	int                mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] seen,
			input logic [31:0] want);
		if (seen !== want) begin
			report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, seen, want));
		end
	endtask

	function automatic tpcd_pkg::result_t blank_result(input tpcd_pkg::kind_t k);
		tpcd_pkg::result_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	task automatic emit(input tpcd_pkg::result_t r);
		pending_results.push_back(r);
		word_hits++;
	endtask

	task automatic open_region();
		mirror.region_peak = '0;
		mirror.region_count = '0;
		mirror.region_sum = '0;
	endtask

	task automatic take_half(input logic [15:0] h);
		tpcd_pkg::result_t r;
		logic [11:0] s;
		s = h[11:0];
		if (h[15:12] == tpcd_tb_pkg::CHAN_TAG) begin
			mirror.current_channel = h[5:0];
			open_region();
			r = blank_result(tpcd_pkg::KIND_CHANNEL);
			r.channel_number = h[5:0];
			emit(r);
		end else if (h[15:14] == tpcd_tb_pkg::TIME_TAG) begin
			if (mirror.region_count != 0 && mirror.region_peak != 0 &&
					mirror.region_sum != 0) begin
				r = blank_result(tpcd_pkg::KIND_PRIM);
				r.channel_number = mirror.current_channel;
				r.peak = mirror.region_peak;
				r.duration = mirror.region_count;
				r.integral = mirror.region_sum;
				r.start_time = mirror.region_time;
				emit(r);
			end
			mirror.region_time = h[13:0];
			open_region();
		end else if (h[15:12] == tpcd_tb_pkg::SAMPLE_TAG_A ||
				h[15:12] == tpcd_tb_pkg::SAMPLE_TAG_B) begin
			if (mirror.region_count != DURATION_CEILING) begin
				mirror.region_count = mirror.region_count + 16'd1;
			end
			if (s > mirror.region_peak) begin
				mirror.region_peak = s;
			end
			if (mirror.region_sum > SUM_CEILING - {16'h0000, s}) begin
				mirror.region_sum = SUM_CEILING;
			end else begin
				mirror.region_sum = mirror.region_sum + {16'h0000, s};
			end
		end
	endtask

	task automatic predict_word(input logic [31:0] w);
		logic [15:0]       lo;
		logic [15:0]       hi;
		logic [5:0]        low6;
		logic              found;
		tpcd_pkg::result_t r;
		lo = w[15:0];
		hi = w[31:16];
		low6 = '0;
		found = 1'b0;
		word_hits = 0;
		if (w == tpcd_tb_pkg::START_WORD) begin
			mirror.header_active = 1'b1;
			mirror.header_count = 4'd1;
		end else if (w != tpcd_tb_pkg::SKIP_WORD) begin
			if (mirror.header_active) begin
				if (mirror.header_count < COUNT_CEILING) begin
					mirror.header_count = mirror.header_count + 4'd1;
				end
				if (mirror.header_count == FRAME_HIGH_WORD) begin
					mirror.frame_high = lo[11:0];
					mirror.frame_middle = hi[11:6];
				end
				if (mirror.header_count == FRAME_LOW_WORD) begin
					if (lo[15:12] == tpcd_tb_pkg::CHAN_TAG) begin
						low6 = lo[11:6];
						found = 1'b1;
					end else if (hi[15:12] == tpcd_tb_pkg::CHAN_TAG) begin
						low6 = hi[11:6];
						found = 1'b1;
					end
					if (found) begin
						r = blank_result(tpcd_pkg::KIND_FRAME);
						r.frame_number = {mirror.frame_high, mirror.frame_middle, low6};
						r.frame_missing = (mirror.expected_frame + 24'd1) != r.frame_number;
						emit(r);
						mirror.expected_frame = r.frame_number;
						mirror.header_active = 1'b0;
						mirror.header_count = '0;
					end
				end
			end
			if (hi[15:8] == tpcd_tb_pkg::FEM_MARK && lo == tpcd_tb_pkg::FEM_LOW) begin
				r = blank_result(tpcd_pkg::KIND_FEM);
				r.fem_number = hi[4:0];
				emit(r);
			end
			take_half(lo);
			take_half(hi);
			// flag the final result of this word
			if (word_hits != 0) begin
				r = pending_results.pop_back();
				r.last = 1'b1;
				pending_results.push_back(r);
			end
		end
	endtask

	task automatic check_result();
		tpcd_pkg::result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result item of kind %0d with nothing expected", kind));
		end else begin
			want = pending_results.pop_front();
			check_field("kind", kind, want.kind);
			check_field("frame_number", frame_number, want.frame_number);
			check_field("frame_missing", frame_missing, want.frame_missing);
			check_field("fem_number", fem_number, want.fem_number);
			check_field("channel_number", channel_number, want.channel_number);
			check_field("peak", peak, want.peak);
			check_field("duration", duration, want.duration);
			check_field("integral", integral, want.integral);
			check_field("start_time", start_time, want.start_time);
			check_field("last", last, want.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror = '0;
			mirror.expected_frame = '1;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (word_valid && word_ready) begin
				predict_word(word);
			end
			if (res_valid && res_ready) begin
				check_result();
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

/* verif/tpc_stream_trigger_primitive_decoder_tb.sv */
// top of the decoder testbench: clock, reset, word stimulus, result stalls and verdict
`timescale 1ns / 100ps

module tpc_stream_trigger_primitive_decoder_tb;

	localparam int RANDOM_WORDS      = 270;
	// a run of full-scale samples building one wide region
	localparam int LONG_REGION_WORDS = 20;
	localparam int SETTLE_CYCLES     = 8;
	localparam int TIMEOUT_NS        = 2_000_000;

	localparam logic [31:0] QUIET_WORD = {tpcd_tb_pkg::IDLE_TAG, 12'h000,
		tpcd_tb_pkg::IDLE_TAG, 12'h000};

	// where header word 8 carries the low frame bits
	typedef enum logic [1:0] {
		LOW_IN_LOW,
		LOW_IN_HIGH,
		LOW_IN_BOTH,
		LOW_MISSING
	} frame_tail_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        word_valid = 1'b0;
	logic        word_ready;
	logic [31:0] word = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [1:0]  kind;
	logic [23:0] frame_number;
	logic        frame_missing;
	logic [4:0]  fem_number;
	logic [5:0]  channel_number;
	logic [11:0] peak;
	logic [15:0] duration;
	logic [27:0] integral;
	logic [13:0] start_time;
	logic        last;

	int          outstanding;
	int          fail_count;
	int          burst_left = 0;
	int          words_sent = 0;
	logic [23:0] next_frame = '0;
	logic [6:0]  rx_phase = '0;

	tpc_stream_trigger_primitive_decoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.word_valid     (word_valid),
		.word_ready     (word_ready),
		.word           (word),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.kind           (kind),
		.frame_number   (frame_number),
		.frame_missing  (frame_missing),
		.fem_number     (fem_number),
		.channel_number (channel_number),
		.peak           (peak),
		.duration       (duration),
		.integral       (integral),
		.start_time     (start_time),
		.last           (last)
	);

	tpcd_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.word_valid     (word_valid),
		.word_ready     (word_ready),
		.word           (word),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.kind           (kind),
		.frame_number   (frame_number),
		.frame_missing  (frame_missing),
		.fem_number     (fem_number),
		.channel_number (channel_number),
		.peak           (peak),
		.duration       (duration),
		.integral       (integral),
		.start_time     (start_time),
		.last           (last),
		.outstanding    (outstanding),
		.fail_count     (fail_count)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: cycles through always-ready, random, fixed-pattern and heavy-stall stretches
	always @(posedge clk) begin
		rx_phase <= rx_phase + 7'd1;
		case (rx_phase[6:5])
			2'd0: res_ready <= 1'b1;
			2'd1: res_ready <= ($urandom_range(0, 2) != 0);
			2'd2: res_ready <= (rx_phase[2:0] != 3'd0) && (rx_phase[2:0] != 3'd3);
			default: res_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// guard against a hung run
	initial begin
		#(TIMEOUT_NS);
		$display("end of test: mismatches");
		$finish;
	end

	// half-word builders
	function automatic logic [15:0] chan_half(input logic [11:0] rest);
		return {tpcd_tb_pkg::CHAN_TAG, rest};
	endfunction

	function automatic logic [15:0] time_half(input logic [13:0] tick);
		return {tpcd_tb_pkg::TIME_TAG, tick};
	endfunction

	function automatic logic [15:0] sample_half(input logic [11:0] s);
		return {(($urandom_range(0, 1) != 0) ? tpcd_tb_pkg::SAMPLE_TAG_B :
			tpcd_tb_pkg::SAMPLE_TAG_A), s};
	endfunction

	// sample value leaning toward zero and full scale
	function automatic logic [11:0] rand_sample();
		int roll;
		roll = $urandom_range(0, 7);
		if (roll == 0) begin
			return 12'h000;
		end
		if (roll == 1) begin
			return 12'hFFF;
		end
		return 12'($urandom);
	endfunction

	// random half weighted toward samples and time headers
	function automatic logic [15:0] any_half(input bit allow_chan);
		int roll;
		roll = $urandom_range(0, 19);
		if (roll <= 10 || (roll <= 16 && roll >= 15 && !allow_chan)) begin
			return sample_half(rand_sample());
		end
		if (roll <= 14) begin
			return time_half(($urandom_range(0, 3) == 0) ? {14{1'($urandom)}} : 14'($urandom));
		end
		if (roll <= 16) begin
			return chan_half(12'($urandom));
		end
		// halves the decoder skips: idle tag or top bit set
		if (roll == 17) begin
			return {tpcd_tb_pkg::IDLE_TAG, 12'($urandom)};
		end
		return {1'b1, 15'($urandom)};
	endfunction

	function automatic logic [31:0] fem_word();
		return {tpcd_tb_pkg::FEM_MARK, 8'($urandom), tpcd_tb_pkg::FEM_LOW};
	endfunction

	// one input item: valid rises after a random gap at the start of each burst,
	// then stays up until the item is taken
	task automatic send_word(input logic [31:0] w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				word_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		word_valid <= 1'b1;
		word <= w;
		@(posedge clk);
		while (!word_ready) @(posedge clk);
		if (w != tpcd_tb_pkg::SKIP_WORD) begin
			words_sent++;
		end
	endtask

	// hold off the sender until every expected result item is out
	task automatic wait_drain();
		word_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic send_payload(input int n);
		// usually open with a channel header
		if ($urandom_range(0, 2) != 0) begin
			send_word({any_half(1), chan_half(12'($urandom))});
			n--;
		end
		repeat (n) send_word({any_half(1), any_half(1)});
	endtask

	// start word, header words 2..8 with the frame number spread over words 5 and 8
	task automatic send_header(input logic [23:0] fr, input frame_tail_t tail);
		logic [15:0] lo8;
		logic [15:0] hi8;
		send_word(tpcd_tb_pkg::START_WORD);
		repeat (3) begin
			// a skipped word inside the header must not advance the count
			if ($urandom_range(0, 7) == 0) begin
				send_word(tpcd_tb_pkg::SKIP_WORD);
			end
			send_word({any_half(1), any_half(1)});
		end
		send_word({4'($urandom), fr[11:6], 6'($urandom), 4'($urandom), fr[23:12]});
		repeat (2) send_word({any_half(1), any_half(1)});
		case (tail)
			LOW_IN_LOW: begin
				lo8 = chan_half({fr[5:0], 6'($urandom)});
				hi8 = any_half(1);
			end
			LOW_IN_HIGH: begin
				lo8 = any_half(0);
				hi8 = chan_half({fr[5:0], 6'($urandom)});
			end
			LOW_IN_BOTH: begin
				lo8 = chan_half({fr[5:0], 6'($urandom)});
				hi8 = chan_half(12'($urandom));
			end
			default: begin
				lo8 = any_half(0);
				hi8 = any_half(0);
			end
		endcase
		send_word({hi8, lo8});
	endtask

	// well-formed frame: header, optional fem marker, data words
	task automatic send_frame_block();
		logic [23:0] fr;
		frame_tail_t tail;
		int          roll;
		roll = $urandom_range(0, 9);
		// mostly the successor, now and then a jump or the wrap point
		if (roll == 0) begin
			fr = 24'($urandom);
		end else if (roll == 1) begin
			fr = 24'hFF_FFFF;
		end else begin
			fr = next_frame;
		end
		roll = $urandom_range(0, 15);
		tail = (roll < 8) ? LOW_IN_LOW : (roll < 12) ? LOW_IN_HIGH :
			(roll < 14) ? LOW_IN_BOTH : LOW_MISSING;
		send_header(fr, tail);
		next_frame = fr + 24'd1;
		if ($urandom_range(0, 2) == 0) begin
			send_word(fem_word());
		end
		// a long tail after a header without frame bits drives the count to its ceiling
		send_payload($urandom_range(2, 14));
	endtask

	initial begin
		bit mid_drained;
		int pick;
		mid_drained = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: ignored word, quiet halves, channel extremes
		send_word(tpcd_tb_pkg::SKIP_WORD);
		send_word(QUIET_WORD);
		send_word({chan_half(12'hFFF), chan_half(12'h000)});
		// full-scale and zero samples, then close with a time header on each half
		send_word({sample_half(12'hFFF), sample_half(12'h000)});
		send_word({time_half(14'h0000), time_half(14'h3FFF)});
		// small region closed from the upper half
		send_word({sample_half(12'h001), sample_half(12'h000)});
		send_word({time_half(14'h1555), sample_half(12'h000)});
		// only zero samples: count without peak, no primitive
		send_word({time_half(14'h2AAA), sample_half(12'h000)});
		// fem markers at both ends of the range
		send_word({tpcd_tb_pkg::FEM_MARK, 8'hFF, tpcd_tb_pkg::FEM_LOW});
		send_word({tpcd_tb_pkg::FEM_MARK, 8'h00, tpcd_tb_pkg::FEM_LOW});
		// header to the all-ones frame, a skipped word inside it,
		// word 8 with a channel half on both sides (lower one wins)
		send_word(tpcd_tb_pkg::START_WORD);
		repeat (3) send_word(QUIET_WORD);
		send_word({tpcd_tb_pkg::IDLE_TAG, 6'h3F, 6'h00, tpcd_tb_pkg::IDLE_TAG, 12'hFFF});
		send_word(tpcd_tb_pkg::SKIP_WORD);
		repeat (2) send_word(QUIET_WORD);
		send_word({chan_half({6'h00, 6'h05}), chan_half({6'h3F, 6'h3F})});
		// next header wraps to frame zero, frame bits from the upper half
		send_word(tpcd_tb_pkg::START_WORD);
		repeat (3) send_word(QUIET_WORD);
		send_word(QUIET_WORD);
		repeat (2) send_word(QUIET_WORD);
		send_word({chan_half(12'h000), sample_half(12'hABC)});
		wait_drain();

		// random: mostly well-formed frames, the rest noise and broken sequences
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				send_frame_block();
			end else if (pick == 6) begin
				repeat ($urandom_range(1, 4)) send_word($urandom);
			end else if (pick == 7) begin
				// header cut short by a fresh start later on
				send_word(tpcd_tb_pkg::START_WORD);
				send_payload($urandom_range(1, 6));
			end else if (pick == 8) begin
				send_word(fem_word());
				send_word(tpcd_tb_pkg::SKIP_WORD);
			end else begin
				send_payload($urandom_range(1, 6));
			end
			if (!mid_drained && words_sent >= RANDOM_WORDS / 2) begin
				wait_drain();
				mid_drained = 1'b1;
			end
		end

		// one wide full-scale region, then close it
		send_word({time_half(14'h3FFF), chan_half(12'h02A)});
		repeat (LONG_REGION_WORDS) send_word({sample_half(12'hFFF), sample_half(12'hFFF)});
		send_word({time_half(14'h0000), time_half(14'h0000)});

		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
